FILE: design/rde_pkg.sv
`default_nettype none

package rde_pkg;

    // Widths of the digit path.
    localparam int DIGIT_W   = 4;
    localparam int CHAR_W    = 7;
    localparam int RADIX_W   = 5;

    // Quotient bits retired by the shared divider in one cycle.
    localparam int STEP_BITS = 8;

    // Radix register reset value and the range that the divider accepts.
    localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd10;
    localparam logic [RADIX_W-1:0] RADIX_MIN   = 5'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX   = 5'd16;

    // ASCII codes that the digit characters are built on.
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'd48;
    localparam logic [CHAR_W-1:0] CHAR_ALPHA = 7'd65;

    // Sequencer states of the top level.
    typedef enum logic [2:0] {
        S_IDLE,
        S_DIVIDE,
        S_PLAY_READ,
        S_PLAY_LOAD,
        S_PLAY_SEND
    } rde_state_t;

    // Commands from the sequencer to the divider.
    typedef struct packed {
        logic start;
        logic load;
    } div_cmd_t;

    // Status from the divider back to the sequencer.
    typedef struct packed {
        logic               busy;
        logic               done;
        logic               quot_zero;
        logic [DIGIT_W-1:0] rem;
    } div_stat_t;

    // Maps a digit value to its ASCII character, 0-9 then A-F.
    function automatic logic [CHAR_W-1:0] digit_to_char(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] ext;
        ext = CHAR_W'(d);
        if (d < 4'd10) begin
            digit_to_char = CHAR_ZERO + ext;
        end else begin
            digit_to_char = CHAR_ALPHA + (ext - 7'd10);
        end
    endfunction

endpackage

`default_nettype wire

FILE: design/radix_digit_emitter_core.sv
`default_nettype none

// Each digit is one run of the shared divider, which retires eight quotient bits a cycle.
// Playback reads each digit from the store, loads it into the output register and then
// offers it until m_axis_tready; s_axis_tready is low from the taking of an item until
// its final digit is taken, so a new item waits until the last one is through.
// Reset: aresetn is synchronous and active low; it sets the radix to 10 and idles the block.
module radix_digit_emitter_core #(
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    // Configuration: the radix register.
    input  wire logic                      cfg_wr_en,
    input  wire logic [4:0]                cfg_wr_data,
    // Input items: value in the low VALUE_WIDTH bits.
    input  wire logic                      s_axis_tvalid,
    output logic                           s_axis_tready,
    input  wire logic [((VALUE_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    // Result items: digit_char in bits 6:0, bit 7 zero.
    output logic                           m_axis_tvalid,
    input  wire logic                      m_axis_tready,
    output logic [7:0]                     m_axis_tdata,
    // Marks the least significant, final digit.
    output logic                           m_axis_tlast
);
    import rde_pkg::*;

    localparam int CHUNKS = (VALUE_WIDTH + STEP_BITS - 1) / STEP_BITS;
    localparam int QW     = CHUNKS * STEP_BITS;
    localparam int DEPTH  = VALUE_WIDTH;
    localparam int AW     = $clog2(DEPTH);
    localparam int CNTW   = $clog2(DEPTH + 1);

    rde_state_t          state_reg;
    rde_state_t          state_next;
    logic [RADIX_W-1:0]  radix_reg;
    logic [RADIX_W-1:0]  radix_eff;
    logic [CNTW-1:0]     count_reg;
    logic [CNTW-1:0]     count_next;
    logic [AW-1:0]       ptr_reg;
    logic [AW-1:0]       ptr_next;
    logic [CHAR_W-1:0]   out_char_reg;
    logic                out_last_reg;
    logic                load_out;
    logic                st_wr_en;
    logic                st_rd_en;
    logic [DIGIT_W-1:0]  st_rd_data;
    div_cmd_t            div_cmd;
    div_stat_t           div_stat;

    // Radix register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radix_reg <= RADIX_RESET;
        end else if (cfg_wr_en) begin
            radix_reg <= cfg_wr_data;
        end
    end

    // Out-of-range radix values are clamped to the nearest legal base.
    always_comb begin
        priority if (radix_reg < RADIX_MIN) begin
            radix_eff = RADIX_MIN;
        end else if (radix_reg > RADIX_MAX) begin
            radix_eff = RADIX_MAX;
        end else begin
            radix_eff = radix_reg;
        end
    end

    // Shared divider: one digit per run, the quotient stays inside it.
    rde_divider #(
        .QW (QW)
    ) u_divider (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (div_cmd),
        .value   (QW'(s_axis_tdata[VALUE_WIDTH-1:0])),
        .radix   (radix_eff),
        .stat    (div_stat)
    );

    // Remainders, least significant first.
    rde_digit_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_digit_store (
        .aclk    (aclk),
        .wr_en   (st_wr_en),
        .wr_addr (count_reg[AW-1:0]),
        .wr_data (div_stat.rem),
        .rd_en   (st_rd_en),
        .rd_addr (ptr_reg),
        .rd_data (st_rd_data)
    );

    // Sequencer state and counters.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            ptr_reg   <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            ptr_reg   <= ptr_next;
        end
    end

    // Next state: divide until the quotient is zero, then play the digits back in reverse.
    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        ptr_next   = ptr_reg;
        div_cmd    = '0;
        st_wr_en   = 1'b0;
        st_rd_en   = 1'b0;
        load_out   = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    div_cmd.start = 1'b1;
                    div_cmd.load  = 1'b1;
                    count_next    = '0;
                    state_next    = S_DIVIDE;
                end
            end
            S_DIVIDE: begin
                if (div_stat.done) begin
                    st_wr_en   = 1'b1;
                    count_next = count_reg + 1'b1;
                    if (div_stat.quot_zero || count_reg == CNTW'(DEPTH - 1)) begin
                        ptr_next   = count_reg[AW-1:0];
                        state_next = S_PLAY_READ;
                    end else begin
                        div_cmd.start = 1'b1;
                    end
                end
            end
            S_PLAY_READ: begin
                st_rd_en   = 1'b1;
                state_next = S_PLAY_LOAD;
            end
            S_PLAY_LOAD: begin
                load_out   = 1'b1;
                state_next = S_PLAY_SEND;
            end
            S_PLAY_SEND: begin
                if (m_axis_tready) begin
                    if (ptr_reg == '0) begin
                        state_next = S_IDLE;
                    end else begin
                        ptr_next   = ptr_reg - 1'b1;
                        state_next = S_PLAY_READ;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output register: the character and its last-digit mark.
    always_ff @(posedge aclk) begin
        if (load_out) begin
            out_char_reg <= digit_to_char(st_rd_data);
            out_last_reg <= (ptr_reg == '0);
        end
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = (state_reg == S_PLAY_SEND);
    assign m_axis_tdata  = {1'b0, out_char_reg};
    assign m_axis_tlast  = out_last_reg;

`ifndef SYNTHESIS
    // A new item is never taken while a result is still on offer.
    a_no_accept_while_sending: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input accepted while a result is pending");

    // Digit store writes stay inside the store.
    a_store_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        st_wr_en |-> (count_reg < CNTW'(DEPTH)))
        else $error("digit store write beyond its depth");

    // The divider only finishes while the sequencer waits for it.
    a_done_in_divide: assert property (@(posedge aclk) disable iff (!aresetn)
        div_stat.done |-> (state_reg == S_DIVIDE))
        else $error("divider finished outside the divide phase");

    // The divider is never running while the block waits for an item.
    a_divider_quiet_when_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE) |-> !div_stat.busy)
        else $error("divider busy while the block is idle");

    // Taking the final digit returns the block to idle.
    a_last_ends_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> s_axis_tready)
        else $error("block not idle after the final digit");
`endif

endmodule

`default_nettype wire

FILE: design/rde_divider.sv
`default_nettype none

module rde_divider #(
    parameter int QW = 32
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire rde_pkg::div_cmd_t          cmd,
    input  wire logic [QW-1:0]              value,
    input  wire logic [rde_pkg::RADIX_W-1:0] radix,
    output rde_pkg::div_stat_t              stat
);
    import rde_pkg::*;

    localparam int CHUNKS = QW / STEP_BITS;
    localparam int CW     = $clog2(CHUNKS + 1);

    logic [QW-1:0]        q_reg;
    logic [QW-1:0]        q_next;
    logic [DIGIT_W-1:0]   rem_reg;
    logic [DIGIT_W-1:0]   rem_next;
    logic [CW-1:0]        cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic [STEP_BITS-1:0] qbits;
    logic [DIGIT_W:0]     partial;

    // One chunk of restoring long division: the top bits of the quotient register
    // are shifted through the remainder and the new quotient bits enter at the bottom.
    always_comb begin
        rem_next = rem_reg;
        qbits    = '0;
        partial  = '0;
        for (int i = 0; i < STEP_BITS; i++) begin
            partial = {rem_next, q_reg[QW-1-i]};
            if (partial >= radix) begin
                partial                 = partial - radix;
                qbits[STEP_BITS-1-i]    = 1'b1;
            end
            rem_next = partial[DIGIT_W-1:0];
        end
        q_next = (q_reg << STEP_BITS) | QW'(qbits);
    end

    // Control: a start runs the division over all CHUNKS chunks, then done pulses for one cycle.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (cmd.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(CHUNKS - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: the quotient is kept in place, the remainder clears per digit.
    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            rem_reg <= '0;
            if (cmd.load) begin
                q_reg <= value;
            end
        end else if (busy_reg) begin
            q_reg   <= q_next;
            rem_reg <= rem_next;
        end
    end

    assign stat.busy      = busy_reg;
    assign stat.done      = done_reg;
    assign stat.quot_zero = (q_reg == '0);
    assign stat.rem       = rem_reg;

endmodule

`default_nettype wire

FILE: design/rde_digit_store.sv
`default_nettype none

module rde_digit_store #(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  wire logic                        aclk,
    input  wire logic                        wr_en,
    input  wire logic [AW-1:0]               wr_addr,
    input  wire logic [rde_pkg::DIGIT_W-1:0] wr_data,
    input  wire logic                        rd_en,
    input  wire logic [AW-1:0]               rd_addr,
    output logic [rde_pkg::DIGIT_W-1:0]      rd_data
);
    import rde_pkg::*;

    logic [DIGIT_W-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire
